/* src/bpc_pkg.sv */
package bpc_pkg;

	localparam int NUM_BUTTONS = 3;
	localparam int MAX_RESULTS = 5;
	localparam int QUEUE_DEPTH = 2;

	localparam int TIME_W  = 32;
	localparam int MS_W    = 16;
	localparam int MASK_W  = 3;
	localparam int BTN_W   = 2;
	localparam int TYPE_W  = 2;
	localparam int CNT_W   = $clog2(MAX_RESULTS + 1);
	localparam int IDX_W   = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;
	localparam int CFG_IDX_W = 2;

	// item kinds
	localparam logic KIND_PIN   = 1'b0;
	localparam logic KIND_CHECK = 1'b1;

	// pin levels (active-low buttons)
	localparam logic LEVEL_PRESSED = 1'b0;

	// event types
	localparam logic [TYPE_W-1:0] EV_SHORT  = 2'd0;
	localparam logic [TYPE_W-1:0] EV_LONG   = 2'd1;
	localparam logic [TYPE_W-1:0] EV_REPEAT = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT_AFTER = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT_MASK  = 2'd2;

	localparam logic [MS_W-1:0]   LONG_PRESS_RST   = 16'd1000;
	localparam logic [MS_W-1:0]   REPEAT_AFTER_RST = 16'd500;
	localparam logic [MASK_W-1:0] REPEAT_MASK_RST  = 3'd5;

	typedef struct packed {
		logic [BTN_W-1:0]  button;
		logic [TYPE_W-1:0] etype;
	} evt_t;

	// all events of one check transaction
	typedef struct packed {
		evt_t [MAX_RESULTS-1:0] evt;
		logic [CNT_W-1:0]       cnt;
	} bundle_t;

endpackage

/* src/bpc_front.sv */
module bpc_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               kind,
	input  logic [bpc_pkg::BTN_W-1:0]          button,
	input  logic                               pin_level,
	input  logic [bpc_pkg::TIME_W-1:0]         now_ms,
	input  logic                               cfg_wr_en,
	input  logic [bpc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [bpc_pkg::MS_W-1:0]           cfg_data,
	input  logic                               q_full,
	output logic                               q_push,
	output bpc_pkg::bundle_t                   q_data
);

	localparam int NB = bpc_pkg::NUM_BUTTONS;

	logic [bpc_pkg::MS_W-1:0]   long_ms_q;
	logic [bpc_pkg::MS_W-1:0]   rep_ms_q;
	logic [bpc_pkg::MASK_W-1:0] rep_mask_q;

	logic [NB-1:0]               held_q, held_nxt;
	logic [NB-1:0]               lrep_q, lrep_nxt;
	logic [bpc_pkg::TIME_W-1:0]  start_q   [NB];
	logic [bpc_pkg::TIME_W-1:0]  start_nxt [NB];
	logic [bpc_pkg::TIME_W-1:0]  elapsed   [NB];
	logic [NB-1:0]               rep_en;
	logic [bpc_pkg::CNT_W-1:0]   n;
	bpc_pkg::bundle_t            bundle;
	logic                        acc;

	assign in_ready = !q_full;
	assign acc      = in_valid && in_ready;
	assign rep_en   = NB'(rep_mask_q);

	always_comb begin
		for (int b = 0; b < NB; b++) begin
			elapsed[b] = now_ms - start_q[b];
		end
	end

	always_comb begin
		held_nxt = held_q;
		lrep_nxt = lrep_q;
		start_nxt = start_q;
		bundle = '0;
		n = '0;
		if (kind == bpc_pkg::KIND_PIN) begin
			for (int b = 0; b < NB; b++) begin
				if (int'(button) == b) begin
					if (pin_level == bpc_pkg::LEVEL_PRESSED) begin
						start_nxt[b] = now_ms;
						held_nxt[b] = 1'b1;
						lrep_nxt[b] = 1'b0;
					end else begin
						held_nxt[b] = 1'b0;
					end
				end
			end
		end else begin
			// scan in button order, at most MAX_RESULTS events
			for (int b = 0; b < NB; b++) begin
				if (held_q[b]) begin
					if (elapsed[b] >= {{(bpc_pkg::TIME_W - bpc_pkg::MS_W){1'b0}}, long_ms_q}
					    && !lrep_q[b] && n < bpc_pkg::MAX_RESULTS) begin
						bundle.evt[n[bpc_pkg::IDX_W-1:0]].button = bpc_pkg::BTN_W'(b);
						bundle.evt[n[bpc_pkg::IDX_W-1:0]].etype = bpc_pkg::EV_LONG;
						lrep_nxt[b] = 1'b1;
						n = n + bpc_pkg::CNT_W'(1);
					end
					if (rep_en[b]
					    && elapsed[b] >= {{(bpc_pkg::TIME_W - bpc_pkg::MS_W){1'b0}}, rep_ms_q}
					    && n < bpc_pkg::MAX_RESULTS) begin
						bundle.evt[n[bpc_pkg::IDX_W-1:0]].button = bpc_pkg::BTN_W'(b);
						bundle.evt[n[bpc_pkg::IDX_W-1:0]].etype = bpc_pkg::EV_REPEAT;
						n = n + bpc_pkg::CNT_W'(1);
					end
				end else if (start_q[b] != '0 && !lrep_q[b]
				             && n < bpc_pkg::MAX_RESULTS) begin
					bundle.evt[n[bpc_pkg::IDX_W-1:0]].button = bpc_pkg::BTN_W'(b);
					bundle.evt[n[bpc_pkg::IDX_W-1:0]].etype = bpc_pkg::EV_SHORT;
					start_nxt[b] = '0;
					n = n + bpc_pkg::CNT_W'(1);
				end
			end
		end
		bundle.cnt = n;
	end

	assign q_push = acc && kind == bpc_pkg::KIND_CHECK && n != '0;
	assign q_data = bundle;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_ms_q <= bpc_pkg::LONG_PRESS_RST;
			rep_ms_q <= bpc_pkg::REPEAT_AFTER_RST;
			rep_mask_q <= bpc_pkg::REPEAT_MASK_RST;
			held_q <= '0;
			lrep_q <= '0;
			for (int b = 0; b < NB; b++) begin
				start_q[b] <= '0;
			end
		end else begin
			if (cfg_wr_en) begin
				unique case (cfg_index)
					bpc_pkg::REG_LONG_PRESS:   long_ms_q <= cfg_data;
					bpc_pkg::REG_REPEAT_AFTER: rep_ms_q <= cfg_data;
					bpc_pkg::REG_REPEAT_MASK:  rep_mask_q <= cfg_data[bpc_pkg::MASK_W-1:0];
					default: ;
				endcase
			end
			if (acc) begin
				held_q <= held_nxt;
				lrep_q <= lrep_nxt;
				start_q <= start_nxt;
			end
		end
	end

endmodule

/* src/bpc_queue.sv */
module bpc_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  bpc_pkg::bundle_t wr_data,
	output logic             full,
	input  logic             pop,
	output logic             rd_valid,
	output bpc_pkg::bundle_t rd_data
);

	localparam int PTR_W = (bpc_pkg::QUEUE_DEPTH > 1) ? $clog2(bpc_pkg::QUEUE_DEPTH) : 1;
	localparam int FILL_W = $clog2(bpc_pkg::QUEUE_DEPTH + 1);

	bpc_pkg::bundle_t   mem_q [bpc_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [FILL_W-1:0]  fill_q;
	logic               do_push, do_pop;

	assign full     = fill_q == FILL_W'(bpc_pkg::QUEUE_DEPTH);
	assign rd_valid = fill_q != '0;
	assign rd_data  = mem_q[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && rd_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(bpc_pkg::QUEUE_DEPTH - 1)) ? '0 :
				            wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(bpc_pkg::QUEUE_DEPTH - 1)) ? '0 :
				            rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + FILL_W'(1);
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - FILL_W'(1);
			end
		end
	end

endmodule

/* src/bpc_back.sv */
module bpc_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_valid,
	input  bpc_pkg::bundle_t             q_data,
	output logic                         q_pop,
	output logic                         active,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [bpc_pkg::BTN_W-1:0]    event_button,
	output logic [bpc_pkg::TYPE_W-1:0]   event_type,
	output logic                         last
);

	bpc_pkg::bundle_t          bundle_q;
	logic [bpc_pkg::CNT_W-1:0] idx_q;
	logic                      active_q;
	logic                      ov_q;
	logic [bpc_pkg::BTN_W-1:0] btn_q;
	logic [bpc_pkg::TYPE_W-1:0] type_q;
	logic                      last_q;
	logic                      adv, is_last;
	bpc_pkg::evt_t             cur;

	assign adv     = !ov_q || out_ready;
	assign cur     = bundle_q.evt[idx_q[bpc_pkg::IDX_W-1:0]];
	assign is_last = (idx_q + bpc_pkg::CNT_W'(1)) == bundle_q.cnt;
	// refill when idle or as the final event of the current bundle leaves
	assign q_pop   = q_valid && (!active_q || (adv && is_last));

	always_ff @(posedge clk) begin
		if (q_pop) begin
			bundle_q <= q_data;
		end
		if (adv) begin
			btn_q <= cur.button;
			type_q <= cur.etype;
			last_q <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			idx_q <= '0;
			ov_q <= 1'b0;
		end else begin
			if (adv) begin
				ov_q <= active_q;
			end
			if (q_pop) begin
				active_q <= 1'b1;
				idx_q <= '0;
			end else if (adv && active_q) begin
				if (is_last) begin
					active_q <= 1'b0;
				end else begin
					idx_q <= idx_q + bpc_pkg::CNT_W'(1);
				end
			end
		end
	end

	assign active       = active_q;
	assign out_valid    = ov_q;
	assign event_button = btn_q;
	assign event_type   = type_q;
	assign last         = last_q;

endmodule

/* src/button_press_classifier.sv */
// A check transaction's first event passes the event queue entry, the back end's bundle register
// and its output register before it is valid on the output.
// One input transaction per cycle is accepted while the two-deep event queue has room; pin
// changes make no events. The back end sends one event per cycle while the receiver is ready,
// so a check's events (up to five) leave one after another; that serializer sets the rate.
// Reset (arst_n low, asynchronous): button state cleared, registers to 1000/500/5, queue empty.
module button_press_classifier (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               kind,
	input  logic [bpc_pkg::BTN_W-1:0]          button,
	input  logic                               pin_level,
	input  logic [bpc_pkg::TIME_W-1:0]         now_ms,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [bpc_pkg::BTN_W-1:0]          event_button,
	output logic [bpc_pkg::TYPE_W-1:0]         event_type,
	output logic                               last,
	input  logic                               cfg_wr_en,
	input  logic [bpc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [bpc_pkg::MS_W-1:0]           cfg_data
);

	// Front end: holds the registers and per-button state. Pin changes update the state
	// directly; a check scans all buttons combinationally, applies the five-event cap and
	// commits long-reported and start-time updates only for events that got a slot.
	// The whole event list of one check travels as a single queue entry.
	logic             q_push, q_full, q_pop, q_valid;
	bpc_pkg::bundle_t q_wdata, q_rdata;
	logic             back_active;

	bpc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.kind      (kind),
		.button    (button),
		.pin_level (pin_level),
		.now_ms    (now_ms),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_data    (q_wdata)
	);

	// Decouples the scan from the serializer so the front keeps taking pin changes
	// and checks while events drain.
	bpc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wr_data  (q_wdata),
		.full     (q_full),
		.pop      (q_pop),
		.rd_valid (q_valid),
		.rd_data  (q_rdata)
	);

	// Back end: walks the event list one per cycle, while the receiver is ready, into an output register; the next
	// list is loaded as the final event of the current one leaves, so no bubble.
	bpc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_data       (q_rdata),
		.q_pop        (q_pop),
		.active       (back_active),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.event_button (event_button),
		.event_type   (event_type),
		.last         (last)
	);

	// never push into a full queue: in_ready must track the queue state
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("event queue overflow");

	// pin changes never produce events
	a_pin_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && kind == bpc_pkg::KIND_PIN) |-> !q_push)
		else $error("pin change produced events");

	// an event that is not the last of its check must have followers pending
	a_more_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !last) |-> back_active)
		else $error("non-final event without pending events");

endmodule

/* tb/tb_button_press_classifier.sv */
module tb_button_press_classifier;
	timeunit 1ns;
	timeprecision 1ps;

	import bpc_pkg::*;

	// button codes as seen on the pin-change transaction
	localparam logic [BTN_W-1:0] BTN_LEFT  = 2'd0;
	localparam logic [BTN_W-1:0] BTN_MID   = 2'd1;
	localparam logic [BTN_W-1:0] BTN_RIGHT = 2'd2;
	localparam logic [BTN_W-1:0] BTN_BAD   = 2'd3;   // out of range, block ignores it

	localparam logic LEVEL_RELEASED = 1'b1;

	localparam logic [3:0] NO_EV = 4'h0;   // filler in the directed table

	localparam int RESET_CYCLES  = 7;
	localparam int SETTLE_CYCLES = 10;     // covers the pipeline, with margin
	localparam int LONG_HOLD     = 80;     // receiver back-pressure stretch
	localparam int END_WAIT      = 4000;
	localparam int MAX_REPORTS   = 10;
	localparam realtime RUN_LIMIT = 4ms;

	// one input transaction, plus hand-typed events where they are obvious
	typedef struct packed {
		logic              kind;
		logic [BTN_W-1:0]  button;
		logic              level;
		logic [TIME_W-1:0] now;
		logic              typed;
		logic [2:0]        n;
		evt_t [0:4]        ev;
	} stim_row_t;

	typedef struct {
		logic [BTN_W-1:0]  button;
		logic [TYPE_W-1:0] etype;
		logic              last;
	} press_event_t;

	// ------------------------------------------------------------------
	// DUT signals
	// ------------------------------------------------------------------
	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic                 kind;
	logic [BTN_W-1:0]     button;
	logic                 pin_level;
	logic [TIME_W-1:0]    now_ms;
	logic                 out_valid;
	logic                 out_ready;
	logic [BTN_W-1:0]     event_button;
	logic [TYPE_W-1:0]    event_type;
	logic                 ev_last;
	logic                 cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [MS_W-1:0]      cfg_data;

	button_press_classifier uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.kind         (kind),
		.button       (button),
		.pin_level    (pin_level),
		.now_ms       (now_ms),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.event_button (event_button),
		.event_type   (event_type),
		.last         (ev_last),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// ------------------------------------------------------------------
	// Press classifier model: per-button state and current register values
	// ------------------------------------------------------------------
	logic              btn_held  [NUM_BUTTONS];
	logic [TIME_W-1:0] t_start   [NUM_BUTTONS];
	logic              long_done [NUM_BUTTONS];
	logic [MS_W-1:0]   cur_long;
	logic [MS_W-1:0]   cur_repeat;
	logic [MASK_W-1:0] cur_mask;
	evt_t              ev_buf    [MAX_RESULTS];

	press_event_t pending_events[$];   // events still owed by the block
	int           fail_count;
	int           holds_requested;
	int           holds_served;
	bit           calm;                // no random idling on either side while set
	logic [TIME_W-1:0] sim_ms;         // running millisecond clock for the random part

	// Applies one transaction to the model; fills ev_buf and returns the event count.
	function automatic int classify_item(logic k, logic [BTN_W-1:0] b, logic lvl,
	                                     logic [TIME_W-1:0] now);
		int cnt;
		logic [TIME_W-1:0] elapsed;
		cnt = 0;
		if (k == KIND_PIN) begin
			if (b < NUM_BUTTONS) begin
				if (lvl == LEVEL_PRESSED) begin
					t_start[b]   = now;
					btn_held[b]  = 1'b1;
					long_done[b] = 1'b0;
				end else begin
					btn_held[b] = 1'b0;
				end
			end
			return 0;
		end
		// scan order is fixed: left, middle, right; at most MAX_RESULTS events
		for (int i = 0; i < NUM_BUTTONS; i++) begin
			elapsed = now - t_start[i];
			if (btn_held[i]) begin
				if (elapsed >= cur_long && !long_done[i] && cnt < MAX_RESULTS) begin
					ev_buf[cnt] = '{button: BTN_W'(i), etype: EV_LONG};
					cnt++;
					long_done[i] = 1'b1;
				end
				if (i < MASK_W && cur_mask[i] && elapsed >= cur_repeat &&
				    cnt < MAX_RESULTS) begin
					ev_buf[cnt] = '{button: BTN_W'(i), etype: EV_REPEAT};
					cnt++;
				end
			end else if (t_start[i] != '0 && !long_done[i] && cnt < MAX_RESULTS) begin
				// short press only if a start time is recorded (zero = none)
				ev_buf[cnt] = '{button: BTN_W'(i), etype: EV_SHORT};
				cnt++;
				t_start[i] = '0;
			end
		end
		return cnt;
	endfunction

	function automatic void note_mismatch(string what);
		fail_count++;
		if (fail_count <= MAX_REPORTS)
			$display("[%0t] MISMATCH %s", $realtime, what);
	endfunction

	// idle stretch length: mostly short, now and then long
	function automatic int idle_len();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// time advance chosen to land near the thresholds fairly often
	function automatic logic [TIME_W-1:0] time_step();
		int r;
		r = $urandom_range(0, 99);
		if (r < 30)
			return $urandom_range(0, 3);
		if (r < 50)
			return TIME_W'(cur_repeat) + $urandom_range(0, 2) - 1;
		if (r < 70)
			return TIME_W'(cur_long) + $urandom_range(0, 2) - 1;
		if (r < 92)
			return $urandom_range(0, 255);
		return $urandom;
	endfunction

	// ------------------------------------------------------------------
	// Directed table. Typed rows carry events readable straight off the
	// rules; the rest rely on the model. Reset registers: 1000 / 500 / 5.
	// ------------------------------------------------------------------
	localparam int DIR_ROWS = 25;
	stim_row_t dir_rows [DIR_ROWS] = '{
		// nothing pressed since reset: silent
		'{KIND_CHECK, BTN_BAD,   LEVEL_RELEASED, 32'd100,        1'b1, 3'd0, '0},
		// press recorded at time zero, i.e. no start time
		'{KIND_PIN,   BTN_LEFT,  LEVEL_PRESSED,  32'd0,          1'b0, 3'd0, '0},
		'{KIND_CHECK, BTN_LEFT,  LEVEL_PRESSED,  32'd600,        1'b1, 3'd1,
			{BTN_LEFT, EV_REPEAT, NO_EV, NO_EV, NO_EV, NO_EV}},
		'{KIND_PIN,   BTN_LEFT,  LEVEL_RELEASED, 32'd700,        1'b0, 3'd0, '0},
		// released but start time zero: no short press
		'{KIND_CHECK, BTN_MID,   LEVEL_RELEASED, 32'd800,        1'b1, 3'd0, '0},
		// middle has repeat disabled at reset
		'{KIND_PIN,   BTN_MID,   LEVEL_PRESSED,  32'd1000,       1'b0, 3'd0, '0},
		'{KIND_CHECK, BTN_RIGHT, LEVEL_PRESSED,  32'd1500,       1'b1, 3'd0, '0},
		'{KIND_PIN,   BTN_MID,   LEVEL_RELEASED, 32'd1600,       1'b0, 3'd0, '0},
		'{KIND_CHECK, BTN_LEFT,  LEVEL_RELEASED, 32'd1700,       1'b1, 3'd1,
			{BTN_MID, EV_SHORT, NO_EV, NO_EV, NO_EV, NO_EV}},
		// start time cleared by the short event
		'{KIND_CHECK, BTN_LEFT,  LEVEL_PRESSED,  32'd1800,       1'b1, 3'd0, '0},
		'{KIND_PIN,   BTN_RIGHT, LEVEL_PRESSED,  32'd2000,       1'b0, 3'd0, '0},
		'{KIND_CHECK, BTN_MID,   LEVEL_PRESSED,  32'd3000,       1'b1, 3'd2,
			{BTN_RIGHT, EV_LONG, BTN_RIGHT, EV_REPEAT, NO_EV, NO_EV, NO_EV}},
		// release after a long press: no short event
		'{KIND_PIN,   BTN_RIGHT, LEVEL_RELEASED, 32'd3100,       1'b0, 3'd0, '0},
		'{KIND_CHECK, BTN_RIGHT, LEVEL_RELEASED, 32'd3200,       1'b1, 3'd0, '0},
		// out-of-range button is ignored
		'{KIND_PIN,   BTN_BAD,   LEVEL_PRESSED,  32'd3300,       1'b0, 3'd0, '0},
		'{KIND_CHECK, BTN_BAD,   LEVEL_PRESSED,  32'hFFFF_FFFF,  1'b1, 3'd0, '0},
		// all three held across the 32-bit wrap
		'{KIND_PIN,   BTN_LEFT,  LEVEL_PRESSED,  32'hFFFF_FF00,  1'b0, 3'd0, '0},
		'{KIND_PIN,   BTN_MID,   LEVEL_PRESSED,  32'hFFFF_FF00,  1'b0, 3'd0, '0},
		'{KIND_PIN,   BTN_RIGHT, LEVEL_PRESSED,  32'hFFFF_FF00,  1'b0, 3'd0, '0},
		'{KIND_CHECK, BTN_LEFT,  LEVEL_RELEASED, 32'h0000_0400,  1'b1, 3'd5,
			{BTN_LEFT, EV_LONG, BTN_LEFT, EV_REPEAT, BTN_MID, EV_LONG,
			 BTN_RIGHT, EV_LONG, BTN_RIGHT, EV_REPEAT}},
		'{KIND_CHECK, BTN_MID,   LEVEL_RELEASED, 32'h0000_0401,  1'b0, 3'd0, '0},
		'{KIND_PIN,   BTN_MID,   LEVEL_RELEASED, 32'h0000_0500,  1'b0, 3'd0, '0},
		'{KIND_PIN,   BTN_LEFT,  LEVEL_RELEASED, 32'h0000_0500,  1'b0, 3'd0, '0},
		'{KIND_CHECK, BTN_RIGHT, LEVEL_PRESSED,  32'h0000_0600,  1'b0, 3'd0, '0},
		'{KIND_PIN,   BTN_RIGHT, LEVEL_RELEASED, 32'h0000_0700,  1'b0, 3'd0, '0}
	};

	// ------------------------------------------------------------------
	// Clock, reset and run limit
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#(RUN_LIMIT);
		$display("tb_button_press_classifier failed");
		$finish;
	end

	// ------------------------------------------------------------------
	// Sender side. Drives at the falling edge, waits for acceptance at the
	// rising edge, then books the expected events for the transaction.
	// ------------------------------------------------------------------
	task automatic send_item(input stim_row_t row);
		int gap;
		int cnt;
		press_event_t pe;
		gap = (calm || $urandom_range(0, 1) == 0) ? 0 : idle_len();
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid  <= 1'b1;
		kind      <= row.kind;
		button    <= row.button;
		pin_level <= row.level;
		now_ms    <= row.now;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		cnt = classify_item(row.kind, row.button, row.level, row.now);
		if (row.typed) begin
			for (int i = 0; i < row.n; i++) begin
				pe.button = row.ev[i].button;
				pe.etype  = row.ev[i].etype;
				pe.last   = (i == row.n - 1);
				pending_events.push_back(pe);
			end
		end else begin
			for (int i = 0; i < cnt; i++) begin
				pe.button = ev_buf[i].button;
				pe.etype  = ev_buf[i].etype;
				pe.last   = (i == cnt - 1);
				pending_events.push_back(pe);
			end
		end
	endtask

	task automatic send_fields(input logic k, input logic [BTN_W-1:0] b, input logic lvl,
	                           input logic [TIME_W-1:0] now);
		stim_row_t row;
		row        = '0;
		row.kind   = k;
		row.button = b;
		row.level  = lvl;
		row.now    = now;
		send_item(row);
	endtask

	// block idle: nothing offered, nothing owed, pipeline flushed
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_events.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MS_W-1:0] data);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		case (idx)
			REG_LONG_PRESS:   cur_long   = data;
			REG_REPEAT_AFTER: cur_repeat = data;
			REG_REPEAT_MASK:  cur_mask   = data[MASK_W-1:0];
			default: ;
		endcase
	endtask

	// upper data bits of the mask write are junk; only the low three count
	task automatic configure(input logic [MS_W-1:0] lp, input logic [MS_W-1:0] ra,
	                         input logic [MASK_W-1:0] msk);
		wait_idle();
		write_reg(REG_LONG_PRESS, lp);
		write_reg(REG_REPEAT_AFTER, ra);
		write_reg(REG_REPEAT_MASK, {13'($urandom), msk});
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// all three buttons down, then checks once both thresholds have passed
	task automatic press_all_then_check();
		for (int b = 0; b < NUM_BUTTONS; b++) begin
			sim_ms += $urandom_range(1, 3);
			send_fields(KIND_PIN, BTN_W'(b), LEVEL_PRESSED, sim_ms);
		end
		sim_ms += (cur_long > cur_repeat) ? cur_long : cur_repeat;
		send_fields(KIND_CHECK, BTN_W'($urandom), 1'($urandom), sim_ms);
		sim_ms += $urandom_range(0, 2);
		send_fields(KIND_CHECK, BTN_W'($urandom), 1'($urandom), sim_ms);
	endtask

	// Random part: mostly press / release / check sequences on a moving
	// clock, some full-chord bursts, and a share of fully random noise.
	task automatic run_random(input int n_items);
		int sent;
		int r;
		logic [BTN_W-1:0] b;
		logic lvl;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(0, 19) == 0)
				calm = ($urandom_range(0, 3) == 0);
			r = $urandom_range(0, 99);
			if (r < 12) begin
				press_all_then_check();
				sent += 5;
			end else if (r < 88) begin
				sim_ms += time_step();
				if ($urandom_range(0, 1) == 0) begin
					send_fields(KIND_CHECK, BTN_W'($urandom), 1'($urandom), sim_ms);
					sent++;
				end else begin
					b   = ($urandom_range(0, 19) == 0) ? BTN_BAD : BTN_W'($urandom_range(0, 2));
					lvl = 1'($urandom);
					// occasionally press exactly at time zero (no start time)
					if (lvl == LEVEL_PRESSED && $urandom_range(0, 29) == 0)
						sim_ms = '0;
					send_fields(KIND_PIN, b, lvl, sim_ms);
					if (b != BTN_BAD)
						sent++;
				end
			end else begin
				b = BTN_W'($urandom);
				r = $urandom_range(0, 1);
				send_fields(1'(r), b, 1'($urandom), $urandom);
				if (!(r == KIND_PIN && b == BTN_BAD))
					sent++;
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Receiver side: random back-pressure, plus a long hold-off on request
	// so the two-deep event queue fills and in_ready drops.
	// ------------------------------------------------------------------
	initial begin
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left  = 0;
		out_ready  = 1'b0;
		holds_served = 0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else if (holds_served < holds_requested) begin
				holds_served++;
				hold_left = LONG_HOLD - 1;
				out_ready <= 1'b0;
			end else if (calm) begin
				out_ready <= 1'b1;
			end else if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else if ($urandom_range(0, 99) < 20) begin
				stall_left = idle_len() - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Event checker: every accepted output transaction against the oldest
	// expectation, field by field.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		press_event_t pe;
		if (arst_n && out_valid && out_ready) begin
			if (pending_events.size() == 0) begin
				note_mismatch($sformatf("unexpected event: btn %0d type %0d last %0d",
					event_button, event_type, ev_last));
			end else begin
				pe = pending_events.pop_front();
				if (event_button !== pe.button || event_type !== pe.etype ||
				    ev_last !== pe.last)
					note_mismatch($sformatf(
						"expected btn %0d type %0d last %0d, got btn %0d type %0d last %0d",
						pe.button, pe.etype, pe.last, event_button, event_type, ev_last));
			end
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		fail_count      = 0;
		holds_requested = 0;
		calm            = 1'b0;
		sim_ms          = '0;
		arst_n          = 1'b0;
		in_valid        = 1'b0;
		kind            = KIND_PIN;
		button          = BTN_LEFT;
		pin_level       = LEVEL_RELEASED;
		now_ms          = '0;
		cfg_wr_en       = 1'b0;
		cfg_index       = REG_LONG_PRESS;
		cfg_data        = '0;
		cur_long        = LONG_PRESS_RST;
		cur_repeat      = REPEAT_AFTER_RST;
		cur_mask        = REPEAT_MASK_RST;
		for (int i = 0; i < NUM_BUTTONS; i++) begin
			btn_held[i]  = 1'b0;
			t_start[i]   = '0;
			long_done[i] = 1'b0;
		end

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed rows under reset register values
		for (int i = 0; i < DIR_ROWS; i++)
			send_item(dir_rows[i]);

		sim_ms = 32'h0000_1000;
		run_random(60);

		// lowest thresholds, repeat on every button: checks overflow the
		// five-event limit; hold the receiver off while checks keep coming
		configure(16'd1, 16'd1, 3'd7);
		press_all_then_check();
		holds_requested++;
		for (int i = 0; i < 15; i++) begin
			sim_ms += 1;
			send_fields(KIND_CHECK, BTN_W'($urandom), 1'($urandom), sim_ms);
		end
		run_random(40);

		configure(16'hFFFF, 16'hFFFF, 3'd0);
		run_random(55);

		configure(16'hFFFF, 16'd1, 3'd3);
		run_random(55);

		configure(16'd1, 16'hFFFF, 3'd6);
		run_random(55);

		configure(MS_W'($urandom_range(1, 65535)), MS_W'($urandom_range(1, 65535)),
			MASK_W'($urandom));
		run_random(60);

		// drain and let the pipeline settle
		@(negedge clk);
		in_valid <= 1'b0;
		for (int w = 0; w < END_WAIT && pending_events.size() != 0; w++)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_events.size() != 0)
			note_mismatch($sformatf("%0d expected events never arrived",
				pending_events.size()));

		if (fail_count == 0)
			$display("tb_button_press_classifier passed");
		else
			$display("tb_button_press_classifier failed");
		$finish;
	end

endmodule

/* button_press_classifier.f */
src/bpc_pkg.sv
src/bpc_front.sv
src/bpc_queue.sv
src/bpc_back.sv
src/button_press_classifier.sv
tb/tb_button_press_classifier.sv
